/* rtl/sparse_power_iteration_unit_defines.svh */
// Assertion macros for the sparse power iteration unit.
// The including module must provide clk_i and rst_ni.
`ifndef SPARSE_POWER_ITERATION_UNIT_DEFINES_SVH
`define SPARSE_POWER_ITERATION_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Checked at every clock edge outside reset.
`define SPI_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("spi assertion failed");
// Checked at every clock edge, reset included.
`define SPI_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("spi assertion failed");
`else
`define SPI_ASSERT(lbl, prop)
`define SPI_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/spi_pkg.sv */
package spi_pkg;

  // Storage sizes.
  localparam int unsigned MAX_DIM = 1024;
  localparam int unsigned MAX_NZ  = 4096;

  // Derived widths.
  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DIM_W  = IDX_W + 1;
  localparam int unsigned NZ_AW  = $clog2(MAX_NZ);
  localparam int unsigned CNT_W  = NZ_AW + 1;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned ACC_W  = 64;
  localparam int unsigned EPS_W  = 30;
  localparam int unsigned ITER_W = 8;
  localparam int unsigned DIFF_W = VAL_W + 1 + IDX_W + 1;
  localparam int unsigned NZ_W   = 2 * IDX_W + VAL_W;

  // Register reset values.
  localparam logic [ITER_W-1:0] MAXIT_RST = ITER_W'(100);
  localparam logic [EPS_W-1:0]  EPS_RST   = EPS_W'(1074);

  // Accumulator saturation bound, 2^62.
  localparam logic signed [ACC_W-1:0] ACC_LIM = ACC_W'(64'h4000_0000_0000_0000);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2,
    STAT_ZERO  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_DIRECTION = 2'd0,
    CFG_DIMENSION = 2'd1,
    CFG_MAX_ITER  = 2'd2,
    CFG_EPSILON   = 2'd3
  } cfg_idx_e;

  // Divider request and response.
  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
    logic signed [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [VAL_W-1:0] quot;
  } div_rsp_t;

  // Result register contents.
  typedef struct packed {
    status_e                  status;
    logic signed [VAL_W-1:0]  value;
    logic        [ITER_W-1:0] iter;
    logic                     conv;
  } rsp_t;

  // Add with saturation at +-2^62.
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                     input logic signed [ACC_W-1:0] b);
    logic signed [ACC_W:0] s;
    logic signed [ACC_W:0] lim;
    s   = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    lim = {1'b0, ACC_LIM};
    if (s > lim) begin
      return ACC_LIM;
    end else if (s < -lim) begin
      return -ACC_LIM;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

/* rtl/spi_in_if.sv */
interface spi_in_if;
  import spi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              operation;
  logic signed [VAL_W-1:0] entry_value;
  logic [IDX_W-1:0]        entry_column;
  logic [IDX_W-1:0]        entry_row;

  modport source (output valid, operation, entry_value, entry_column, entry_row,
                  input ready);
  modport sink (input valid, operation, entry_value, entry_column, entry_row,
                output ready);
endinterface

/* rtl/spi_out_if.sv */
interface spi_out_if;
  import spi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [1:0]              status;
  logic signed [VAL_W-1:0] vector_value;
  logic [ITER_W-1:0]       iteration_count;
  logic                    converged;

  modport source (output valid, status, vector_value, iteration_count, converged,
                  input ready);
  modport sink (input valid, status, vector_value, iteration_count, converged,
                output ready);
endinterface

/* rtl/spi_ram.sv */
module spi_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [Width-1:0]           wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [Width-1:0]           rdata_o
);
  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

/* rtl/spi_div.sv */
module spi_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  spi_pkg::div_req_t req_i,
  output spi_pkg::div_rsp_t rsp_o
);
  import spi_pkg::*;

  localparam int unsigned FRAC_STEPS = 30;
  localparam int unsigned STEP_W     = $clog2(FRAC_STEPS);

  logic                busy_q, done_q;
  logic [STEP_W-1:0]   cnt_q;
  logic                neg_q, sat_q;
  logic [ACC_W-1:0]    r_q, b_q;
  logic [FRAC_STEPS:0] q_q;

  logic [ACC_W-1:0]    a_abs, b_abs, r2;
  logic                ovf, ge0, ge;

  // Magnitudes and first quotient bit.
  always_comb begin
    a_abs = req_i.num[ACC_W-1] ? ACC_W'(-req_i.num) : ACC_W'(req_i.num);
    b_abs = req_i.den[ACC_W-1] ? ACC_W'(-req_i.den) : ACC_W'(req_i.den);
    ovf   = {1'b0, a_abs} >= {b_abs, 1'b0};
    ge0   = a_abs >= b_abs;
    r2    = {r_q[ACC_W-2:0], 1'b0};
    ge    = r2 >= b_q;
  end

  // Control: one restoring step per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= !ovf;
        done_q <= ovf;
        cnt_q  <= STEP_W'(FRAC_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      neg_q <= req_i.num[ACC_W-1] ^ req_i.den[ACC_W-1];
      sat_q <= ovf;
      b_q   <= b_abs;
      q_q   <= {{FRAC_STEPS{1'b0}}, ge0};
      r_q   <= ge0 ? a_abs - b_abs : a_abs;
    end else if (busy_q) begin
      r_q <= ge ? r2 - b_q : r2;
      q_q <= {q_q[FRAC_STEPS-1:0], ge};
    end
  end

  // Sign and saturation of the result.
  always_comb begin
    rsp_o.done = done_q;
    if (sat_q) begin
      rsp_o.quot = neg_q ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      rsp_o.quot = neg_q ? -VAL_W'(q_q) : VAL_W'(q_q);
    end
  end
endmodule

/* rtl/sparse_power_iteration_unit.sv */
// Sparse power iteration unit, coordinate-list store in on-chip memory.
// Requests arrive on req_i (valid/ready): load a nonzero (row, column,
// Q16.16 value, rows nondecreasing), start a solve, or read an element of
// the Q2.30 eigenvector. Every request yields exactly one response on rsp_o
// with status, element value, pass count and converged flag.
// Configuration (direction, dimension, iteration limit, epsilon) is written
// through cfg_we_i/cfg_index_i/cfg_wdata_i while the unit is idle; the user
// must keep to this, as the block itself does not enforce it. A load or a
// rejected request answers in the cycle after acceptance; a read passes
// through S_READ before its response is registered. A solve divides for
// the start value and writes the start vector; each pass then clears the
// accumulators, multiplies and accumulates the stored nonzeros in use,
// sums and checks the total, and normalizes each element through the
// shared serial divider before closing the pass. Loads sustain one request
// per cycle while responses are taken; an in-range read holds off the input
// in S_READ, and a solve holds off new requests until it ends. A response
// that is held blocks the next request until the result register is taken.
// Reset empties the matrix store and restores register defaults; vector
// contents are undefined until the first solve.
`include "sparse_power_iteration_unit_defines.svh"
module sparse_power_iteration_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  spi_in_if.sink                    req_i,
  spi_out_if.source                 rsp_o,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [spi_pkg::EPS_W-1:0] cfg_wdata_i
);
  import spi_pkg::*;

  typedef enum logic [14:0] {
    S_IDLE     = 15'h0001,
    S_READ     = 15'h0002,
    S_INIT_DIV = 15'h0004,
    S_INIT_WR  = 15'h0008,
    S_CLR      = 15'h0010,
    S_M_NZ     = 15'h0020,
    S_M_X      = 15'h0040,
    S_M_MUL    = 15'h0080,
    S_M_ACC    = 15'h0100,
    S_SUM      = 15'h0200,
    S_CHK      = 15'h0400,
    S_NRM_RD   = 15'h0800,
    S_NRM_DIV  = 15'h1000,
    S_NRM_WAIT = 15'h2000,
    S_NRM_END  = 15'h4000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic              dir_q;
  logic [DIM_W-1:0]  dim_cfg_q;
  logic [ITER_W-1:0] maxit_q;
  logic [EPS_W-1:0]  eps_q;

  // Control state.
  logic [CNT_W-1:0]  nz_cnt_q, nz_cnt_d;
  logic [DIM_W-1:0]  last_row_q, last_row_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              conv_q, conv_d;
  logic              bank_q, bank_d;
  logic              sum_vld_q, sum_vld_d;
  logic              out_vld_q, out_vld_d;

  // Solve datapath.
  logic [DIM_W-1:0]        dim_q, dim_d;
  logic [ITER_W-1:0]       lim_q, lim_d;
  logic [DIM_W-1:0]        i_q, i_d;
  logic [CNT_W-1:0]        k_q, k_d;
  logic signed [VAL_W-1:0] init_q, init_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [IDX_W-1:0]        ai_q, ai_d;
  logic signed [ACC_W-1:0] prod_q, prod_d;
  logic signed [ACC_W-1:0] acc_old_q, acc_old_d;
  logic signed [ACC_W-1:0] total_q, total_d;
  logic signed [VAL_W-1:0] old_q, old_d;
  logic [DIFF_W-1:0]       diff_q, diff_d;
  rsp_t                    out_q, out_d;

  // Memory ports.
  logic                    nz_we;
  logic [NZ_W-1:0]         nz_wdata, nz_rd;
  logic                    vec_we, vec_wbank;
  logic [IDX_W-1:0]        vec_waddr, vec_raddr;
  logic signed [VAL_W-1:0] vec_wdata;
  logic [VAL_W-1:0]        vec0_rd, vec1_rd;
  logic signed [VAL_W-1:0] vec_rd;
  logic                    acc_we;
  logic [IDX_W-1:0]        acc_waddr, acc_raddr;
  logic signed [ACC_W-1:0] acc_wdata;
  logic [ACC_W-1:0]        acc_rd;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                    req_acc;
  logic [DIM_W-1:0]        eff_dim, half_dim, row_p1;
  logic [IDX_W-1:0]        nz_row, nz_col;
  logic signed [VAL_W-1:0] nz_val;
  logic                    push;
  status_e                 push_status;
  logic signed [VAL_W-1:0] push_value;
  logic signed [VAL_W:0]   dd, dd_abs;

  // Memories: nonzeros, two vector banks, accumulators.
  spi_ram #(.Width(NZ_W), .Depth(MAX_NZ)) u_nz_ram (
    .clk_i, .we_i(nz_we), .waddr_i(nz_cnt_q[NZ_AW-1:0]), .wdata_i(nz_wdata),
    .raddr_i(k_q[NZ_AW-1:0]), .rdata_o(nz_rd)
  );

  spi_ram #(.Width(VAL_W), .Depth(MAX_DIM)) u_vec0_ram (
    .clk_i, .we_i(vec_we && !vec_wbank), .waddr_i(vec_waddr), .wdata_i(vec_wdata),
    .raddr_i(vec_raddr), .rdata_o(vec0_rd)
  );

  spi_ram #(.Width(VAL_W), .Depth(MAX_DIM)) u_vec1_ram (
    .clk_i, .we_i(vec_we && vec_wbank), .waddr_i(vec_waddr), .wdata_i(vec_wdata),
    .raddr_i(vec_raddr), .rdata_o(vec1_rd)
  );

  spi_ram #(.Width(ACC_W), .Depth(MAX_DIM)) u_acc_ram (
    .clk_i, .we_i(acc_we), .waddr_i(acc_waddr), .wdata_i(acc_wdata),
    .raddr_i(acc_raddr), .rdata_o(acc_rd)
  );

  spi_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  // Handshake and field decode.
  assign req_i.ready = (state_q == S_IDLE) && (!out_vld_q || rsp_o.ready);
  assign req_acc     = req_i.valid && req_i.ready;
  assign nz_row      = nz_rd[NZ_W-1 -: IDX_W];
  assign nz_col      = nz_rd[VAL_W +: IDX_W];
  assign nz_val      = nz_rd[VAL_W-1:0];
  assign nz_wdata    = {req_i.entry_row, req_i.entry_column, req_i.entry_value};
  assign vec_rd      = bank_q ? vec1_rd : vec0_rd;
  assign row_p1      = DIM_W'(req_i.entry_row) + 1'b1;

  // Effective dimension and half of it, rounded up.
  always_comb begin
    if (dim_cfg_q == '0) begin
      eff_dim = DIM_W'(1);
    end else if (dim_cfg_q > DIM_W'(MAX_DIM)) begin
      eff_dim = DIM_W'(MAX_DIM);
    end else begin
      eff_dim = dim_cfg_q;
    end
    half_dim = DIM_W'(({1'b0, eff_dim} + 1'b1) >> 1);
  end

  // Read address selection.
  always_comb begin
    case (state_q)
      S_M_X:    vec_raddr = dir_q ? nz_row : nz_col;
      S_NRM_RD: vec_raddr = i_q[IDX_W-1:0];
      default:  vec_raddr = req_i.entry_column;
    endcase
    acc_raddr = (state_q == S_M_X) ? (dir_q ? nz_col : nz_row) : i_q[IDX_W-1:0];
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    nz_cnt_d    = nz_cnt_q;
    last_row_d  = last_row_q;
    iter_d      = iter_q;
    conv_d      = conv_q;
    bank_d      = bank_q;
    sum_vld_d   = sum_vld_q;
    dim_d       = dim_q;
    lim_d       = lim_q;
    i_d         = i_q;
    k_d         = k_q;
    init_d      = init_q;
    val_d       = val_q;
    ai_d        = ai_q;
    prod_d      = prod_q;
    acc_old_d   = acc_old_q;
    total_d     = total_q;
    old_d       = old_q;
    diff_d      = diff_q;
    out_d       = out_q;
    push        = 1'b0;
    push_status = STAT_OK;
    push_value  = '0;
    nz_we       = 1'b0;
    vec_we      = 1'b0;
    vec_wbank   = bank_q;
    vec_waddr   = i_q[IDX_W-1:0];
    vec_wdata   = '0;
    acc_we      = 1'b0;
    acc_waddr   = i_q[IDX_W-1:0];
    acc_wdata   = '0;
    div_req     = '0;
    dd          = {div_rsp.quot[VAL_W-1], div_rsp.quot} - {old_q[VAL_W-1], old_q};
    dd_abs      = dd[VAL_W] ? -dd : dd;

    unique case (state_q)
      S_IDLE: begin
        if (req_acc) begin
          case (req_i.operation)
            OP_LOAD: begin
              push = 1'b1;
              if (row_p1 < last_row_q) begin
                push_status = STAT_RANGE;
              end else if (nz_cnt_q[NZ_AW]) begin
                push_status = STAT_FULL;
              end else begin
                nz_we    = 1'b1;
                nz_cnt_d = nz_cnt_q + 1'b1;
                if (row_p1 > last_row_q) begin
                  last_row_d = row_p1;
                end
              end
            end
            OP_SOLVE: begin
              dim_d         = eff_dim;
              lim_d         = (maxit_q == '0) ? ITER_W'(1) : maxit_q;
              iter_d        = '0;
              conv_d        = 1'b0;
              div_req.start = 1'b1;
              div_req.num   = ACC_W'(1);
              div_req.den   = ACC_W'(half_dim);
              state_d       = S_INIT_DIV;
            end
            OP_READ: begin
              if (DIM_W'(req_i.entry_column) < eff_dim) begin
                state_d = S_READ;
              end else begin
                push        = 1'b1;
                push_status = STAT_RANGE;
              end
            end
            default: begin
              push        = 1'b1;
              push_status = STAT_RANGE;
            end
          endcase
        end
      end
      S_READ: begin
        push       = 1'b1;
        push_value = vec_rd;
        state_d    = S_IDLE;
      end
      S_INIT_DIV: begin
        if (div_rsp.done) begin
          init_d  = div_rsp.quot;
          i_d     = '0;
          state_d = S_INIT_WR;
        end
      end
      S_INIT_WR: begin
        vec_we    = 1'b1;
        vec_wdata = i_q[0] ? '0 : init_q;
        if (i_q + 1'b1 == dim_q) begin
          i_d     = '0;
          state_d = S_CLR;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_CLR: begin
        acc_we = 1'b1;
        if (i_q + 1'b1 == dim_q) begin
          k_d     = '0;
          state_d = S_M_NZ;
        end else begin
          i_d = i_q + 1'b1;
        end
      end
      S_M_NZ: begin
        if (k_q == nz_cnt_q) begin
          i_d       = '0;
          total_d   = '0;
          sum_vld_d = 1'b0;
          state_d   = S_SUM;
        end else begin
          state_d = S_M_X;
        end
      end
      S_M_X: begin
        // Entries outside the active square are skipped.
        if (DIM_W'(nz_row) >= dim_q || DIM_W'(nz_col) >= dim_q) begin
          k_d     = k_q + 1'b1;
          state_d = S_M_NZ;
        end else begin
          val_d   = nz_val;
          ai_d    = dir_q ? nz_col : nz_row;
          state_d = S_M_MUL;
        end
      end
      S_M_MUL: begin
        prod_d    = val_q * vec_rd;
        acc_old_d = acc_rd;
        state_d   = S_M_ACC;
      end
      S_M_ACC: begin
        acc_we    = 1'b1;
        acc_waddr = ai_q;
        acc_wdata = sat_add(acc_old_q, prod_q >>> 16);
        k_d       = k_q + 1'b1;
        state_d   = S_M_NZ;
      end
      S_SUM: begin
        if (sum_vld_q) begin
          total_d = sat_add(total_q, acc_rd);
        end
        if (i_q != dim_q) begin
          i_d       = i_q + 1'b1;
          sum_vld_d = 1'b1;
        end else begin
          sum_vld_d = 1'b0;
          if (!sum_vld_q) begin
            state_d = S_CHK;
          end
        end
      end
      S_CHK: begin
        iter_d = iter_q + 1'b1;
        if (total_q == '0) begin
          push        = 1'b1;
          push_status = STAT_ZERO;
          state_d     = S_IDLE;
        end else begin
          i_d     = '0;
          diff_d  = '0;
          state_d = S_NRM_RD;
        end
      end
      S_NRM_RD: begin
        state_d = S_NRM_DIV;
      end
      S_NRM_DIV: begin
        div_req.start = 1'b1;
        div_req.num   = acc_rd;
        div_req.den   = total_q;
        old_d         = vec_rd;
        state_d       = S_NRM_WAIT;
      end
      S_NRM_WAIT: begin
        if (div_rsp.done) begin
          vec_we    = 1'b1;
          vec_wbank = !bank_q;
          vec_wdata = div_rsp.quot;
          diff_d    = diff_q + DIFF_W'(unsigned'(dd_abs));
          if (i_q + 1'b1 == dim_q) begin
            state_d = S_NRM_END;
          end else begin
            i_d     = i_q + 1'b1;
            state_d = S_NRM_RD;
          end
        end
      end
      S_NRM_END: begin
        bank_d = !bank_q;
        if (diff_q < DIFF_W'(eps_q)) begin
          conv_d  = 1'b1;
          push    = 1'b1;
          state_d = S_IDLE;
        end else if (iter_q == lim_q) begin
          push    = 1'b1;
          state_d = S_IDLE;
        end else begin
          i_d     = '0;
          state_d = S_CLR;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // Result register and its valid flag.
    if (push) begin
      out_d = '{status: push_status, value: push_value, iter: iter_d, conv: conv_d};
    end
    out_vld_d = push ? 1'b1 : (rsp_o.ready ? 1'b0 : out_vld_q);
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      nz_cnt_q   <= '0;
      last_row_q <= '0;
      iter_q     <= '0;
      conv_q     <= 1'b0;
      bank_q     <= 1'b0;
      sum_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      nz_cnt_q   <= nz_cnt_d;
      last_row_q <= last_row_d;
      iter_q     <= iter_d;
      conv_q     <= conv_d;
      bank_q     <= bank_d;
      sum_vld_q  <= sum_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q     <= 1'b0;
      dim_cfg_q <= DIM_W'(1);
      maxit_q   <= MAXIT_RST;
      eps_q     <= EPS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DIRECTION: dir_q     <= cfg_wdata_i[0];
        CFG_DIMENSION: dim_cfg_q <= cfg_wdata_i[DIM_W-1:0];
        CFG_MAX_ITER:  maxit_q   <= cfg_wdata_i[ITER_W-1:0];
        CFG_EPSILON:   eps_q     <= cfg_wdata_i;
        default:       dir_q     <= dir_q;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dim_q     <= dim_d;
    lim_q     <= lim_d;
    i_q       <= i_d;
    k_q       <= k_d;
    init_q    <= init_d;
    val_q     <= val_d;
    ai_q      <= ai_d;
    prod_q    <= prod_d;
    acc_old_q <= acc_old_d;
    total_q   <= total_d;
    old_q     <= old_d;
    diff_q    <= diff_d;
    out_q     <= out_d;
  end

  // Response channel.
  assign rsp_o.valid           = out_vld_q;
  assign rsp_o.status          = out_q.status;
  assign rsp_o.vector_value    = out_q.value;
  assign rsp_o.iteration_count = out_q.iter;
  assign rsp_o.converged       = out_q.conv;

  // The divider answers only while a state waits for it.
  `SPI_ASSERT(a_div_done_expected,
              div_rsp.done |-> (state_q == S_INIT_DIV || state_q == S_NRM_WAIT))
  // An accepted solve starts with the start-value division.
  `SPI_ASSERT(a_solve_starts,
              (req_acc && req_i.operation == OP_SOLVE) |=> state_q == S_INIT_DIV)
  // A converged solve performed at least one pass.
  `SPI_ASSERT_ALWAYS(a_conv_has_pass, conv_q |-> iter_q != '0)
  // The pass count stays within the limit of the running solve.
  `SPI_ASSERT(a_iter_bounded, (state_q != S_IDLE && state_q != S_READ) |-> iter_q <= lim_q)
endmodule
